// ===== hdl/zrld_pkg.sv =====
// zrld_pkg: shared types and codes for the zero-run / literal stream decoder
// no dependencies; imported by zero_run_literal_decoder_unit
package zrld_pkg;

  // configuration register indexes
  localparam logic REG_CODEC_ID      = 1'b0;
  localparam logic REG_EXPECTED_SIZE = 1'b1;

  // status codes reported with the last beat of a stream
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL     = 4'd1;
  localparam logic [3:0] ST_BAD_CODEC     = 4'd2;
  localparam logic [3:0] ST_SIZE_MISMATCH = 4'd3;
  localparam logic [3:0] ST_TRUNC_VARINT  = 4'd4;
  localparam logic [3:0] ST_VARINT_LARGE  = 4'd5;
  localparam logic [3:0] ST_ZERO_RUN      = 4'd6;
  localparam logic [3:0] ST_OVERFLOW      = 4'd7;
  localparam logic [3:0] ST_UNKNOWN_TOKEN = 4'd8;
  localparam logic [3:0] ST_TRUNC_LITERAL = 4'd9;
  localparam logic [3:0] ST_SHORT_OUTPUT  = 4'd10;

  // token bytes
  localparam logic [7:0] TOK_ZERO_RUN = 8'h00;
  localparam logic [7:0] TOK_LITERAL  = 8'h01;

  localparam int unsigned MAX_LEN_BYTES = 9;
  localparam int unsigned HEADER_LAST   = 4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] repeat_count;
    logic        data_valid;
    logic        done_res;
    logic [3:0]  status;
  } zrld_res_t;

endpackage

// ===== hdl/zero_run_literal_decoder_unit.sv =====
// zero_run_literal_decoder_unit: decodes a zero-run / literal token stream
// depends on zrld_pkg (codes and result type)
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall   | in_byte, last
//  out     | source    | out_valid/out_stall | out_byte, repeat_count, data_valid,
//          |           |                     | done_res, status
//  cfg     | sink      | cfg_write           | cfg_index, cfg_data
//
// one beat per cycle sustained while in_stall is low: input register,
// one pass of decode logic, result register, which takes each result while out is free
// a skid register behind the result register absorbs one result while out is stalled
// in_stall rises only when the skid register is full and an item waits in the input register
// rst is synchronous and clears stream state, configuration and all valid flags
module zero_run_literal_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [31:0] repeat_count,
  output logic        data_valid,
  output logic        done_res,
  output logic [3:0]  status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import zrld_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_TOKEN   = 2'd1;
  localparam logic [1:0] PH_LENGTH  = 2'd2;
  localparam logic [1:0] PH_LITERAL = 2'd3;

  // configuration
  logic [7:0]  codec_id;
  logic [31:0] expected_size;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  // stream state
  logic [1:0]  phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic        codec_bad, codec_bad_next;
  logic [31:0] declared_size, declared_size_next;
  logic [7:0]  token_value, token_value_next;
  logic [62:0] length_accum, length_accum_next;
  logic [3:0]  length_bytes, length_bytes_next;
  logic [31:0] produced_count, produced_count_next;
  // a literal run never exceeds the remaining room, so 32 bits hold it
  logic [31:0] literal_left, literal_left_next;
  logic [3:0]  error_code, error_code_next;

  // result and skid registers
  zrld_res_t   out_res;
  logic        skid_valid;
  zrld_res_t   skid_res;

  logic        advance;
  logic        produce;
  logic        emit;
  zrld_res_t   res;
  logic [1:0]  lane;
  logic [6:0]  shamt7;
  logic [31:0] room;
  logic        out_taken;

  assign advance   = s1_valid && !skid_valid;
  assign in_stall  = s1_valid && skid_valid;
  assign out_taken = out_valid && !out_stall;

  assign lane   = header_count[1:0] - 2'd1;
  assign shamt7 = 7'(length_bytes) * 7'd7;
  assign room   = declared_size - produced_count;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    codec_bad_next      = codec_bad;
    declared_size_next  = declared_size;
    token_value_next    = token_value;
    length_accum_next   = length_accum;
    length_bytes_next   = length_bytes;
    produced_count_next = produced_count;
    literal_left_next   = literal_left;
    error_code_next     = error_code;
    emit                = 1'b0;
    res                 = '0;

    if (error_code == ST_OK) begin
      case (phase)
        PH_HEADER: begin
          if (header_count == 3'd0) begin
            codec_bad_next = (s1_byte != codec_id);
          end else begin
            declared_size_next = declared_size | ({24'd0, s1_byte} << {lane, 3'b000});
          end
          if (header_count >= 3'(HEADER_LAST)) begin
            if (codec_bad) begin
              error_code_next = ST_BAD_CODEC;
            end else if (declared_size_next != expected_size) begin
              error_code_next = ST_SIZE_MISMATCH;
            end else begin
              phase_next = PH_TOKEN;
            end
          end else begin
            header_count_next = header_count + 3'd1;
          end
        end
        PH_TOKEN: begin
          token_value_next  = s1_byte;
          length_accum_next = '0;
          length_bytes_next = '0;
          phase_next        = PH_LENGTH;
        end
        PH_LENGTH: begin
          length_accum_next = length_accum | ({56'd0, s1_byte[6:0]} << shamt7[5:0]);
          length_bytes_next = length_bytes + 4'd1;
          if (s1_byte[7]) begin
            if (!s1_last && length_bytes_next >= 4'(MAX_LEN_BYTES)) begin
              error_code_next = ST_VARINT_LARGE;
            end
          end else if (length_accum_next == '0) begin
            error_code_next = ST_ZERO_RUN;
          end else if (length_accum_next > {31'd0, room}) begin
            error_code_next = ST_OVERFLOW;
          end else if (token_value == TOK_ZERO_RUN) begin
            produced_count_next = produced_count + length_accum_next[31:0];
            emit                = 1'b1;
            res.out_byte        = 8'd0;
            res.repeat_count    = length_accum_next[31:0];
            phase_next          = PH_TOKEN;
          end else if (token_value == TOK_LITERAL) begin
            literal_left_next = length_accum_next[31:0];
            phase_next        = PH_LITERAL;
          end else begin
            error_code_next = ST_UNKNOWN_TOKEN;
          end
        end
        PH_LITERAL: begin
          emit                = 1'b1;
          res.out_byte        = s1_byte;
          res.repeat_count    = 32'd1;
          produced_count_next = produced_count + 32'd1;
          literal_left_next   = literal_left - 32'd1;
          if (literal_left_next == '0) begin
            phase_next = PH_TOKEN;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end

    res.data_valid = emit;
    res.done_res   = s1_last;

    if (s1_last) begin
      if (error_code_next == ST_OK) begin
        if (phase_next == PH_HEADER) begin
          error_code_next = ST_TOO_SMALL;
        end else if (phase_next == PH_LENGTH) begin
          error_code_next = ST_TRUNC_VARINT;
        end else if (phase_next == PH_LITERAL) begin
          error_code_next = ST_TRUNC_LITERAL;
        end else if (produced_count_next != declared_size_next) begin
          error_code_next = ST_SHORT_OUTPUT;
        end
      end
      res.status = error_code_next;
      // stream closes: back to the header phase
      phase_next          = PH_HEADER;
      header_count_next   = '0;
      codec_bad_next      = 1'b0;
      declared_size_next  = '0;
      token_value_next    = '0;
      length_accum_next   = '0;
      length_bytes_next   = '0;
      produced_count_next = '0;
      literal_left_next   = '0;
      error_code_next     = ST_OK;
    end

    produce = emit || s1_last;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      codec_id      <= '0;
      expected_size <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CODEC_ID:      codec_id      <= cfg_data[7:0];
        REG_EXPECTED_SIZE: expected_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
      s1_last <= last;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= '0;
      codec_bad      <= 1'b0;
      declared_size  <= '0;
      token_value    <= '0;
      length_accum   <= '0;
      length_bytes   <= '0;
      produced_count <= '0;
      literal_left   <= '0;
      error_code     <= ST_OK;
    end else if (advance) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      codec_bad      <= codec_bad_next;
      declared_size  <= declared_size_next;
      token_value    <= token_value_next;
      length_accum   <= length_accum_next;
      length_bytes   <= length_bytes_next;
      produced_count <= produced_count_next;
      literal_left   <= literal_left_next;
      error_code     <= error_code_next;
    end
  end

  // result register with skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance && produce) begin
      if (!out_valid || out_taken) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_taken) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
    if (advance && produce) begin
      if (!out_valid || out_taken) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (out_taken && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign out_byte     = out_res.out_byte;
  assign repeat_count = out_res.repeat_count;
  assign data_valid   = out_res.data_valid;
  assign done_res     = out_res.done_res;
  assign status       = out_res.status;

  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while result register is empty");

  // status is only reported on the closing beat
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |-> out_res.status == ST_OK)
    else $error("nonzero status on a beat that does not close the stream");

  // once an error is latched no data leaves
  a_no_data_after_error: assert property (@(posedge clk) disable iff (rst)
    advance && error_code != ST_OK |-> !emit)
    else $error("data emitted after an error was latched");

  // output never exceeds the declared size
  a_produced_bound: assert property (@(posedge clk) disable iff (rst)
    produced_count <= declared_size)
    else $error("produced count passed declared size");

  // stream state returns to header after a closing beat
  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> phase == PH_HEADER && error_code == ST_OK)
    else $error("stream state not cleared after last beat");

endmodule
